@@ rtl/sha_pkg.sv @@
// Shared types, constants and round functions of the SHA-256 hasher.
package sha_pkg;

    typedef logic [31:0] t_word;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int unsigned LEN_POS = 56;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word v;
        begin
            case (idx)
                3'd0: v = 32'h6a09e667;
                3'd1: v = 32'hbb67ae85;
                3'd2: v = 32'h3c6ef372;
                3'd3: v = 32'ha54ff53a;
                3'd4: v = 32'h510e527f;
                3'd5: v = 32'h9b05688c;
                3'd6: v = 32'h1f83d9ab;
                default: v = 32'h5be0cd19;
            endcase
            return v;
        end
    endfunction

    function automatic t_word round_const(input logic [5:0] t);
        t_word k;
        begin
            case (t)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/sha_in_if.sv @@
// Input channel of the hasher: command and message byte.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] message_byte;

    modport source (output valid, output command, output message_byte, input ready);
    modport sink (input valid, input command, input message_byte, output ready);
endinterface

@@ rtl/sha_out_if.sv @@
// Output channel of the hasher: one digest word per beat.
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

@@ rtl/sha_round.sv @@
// One SHA-256 round: message schedule word and working variable update.
module sha_round (
    input  sha_pkg::t_word i_vars [8],
    input  sha_pkg::t_word i_win [16],
    input  sha_pkg::t_word i_blk_word,
    input  logic           i_use_blk,
    input  logic [5:0]     i_rnd,
    output sha_pkg::t_word o_vars [8],
    output sha_pkg::t_word o_w
);

    sha_pkg::t_word s0, s1, w, e, a, t1, t2;

    always_comb begin
        // The window holds W[t-16] at index 0 up to W[t-1] at index 15.
        s1 = sha_pkg::rotr(i_win[14], 17) ^ sha_pkg::rotr(i_win[14], 19) ^ (i_win[14] >> 10);
        s0 = sha_pkg::rotr(i_win[1], 7) ^ sha_pkg::rotr(i_win[1], 18) ^ (i_win[1] >> 3);
        w  = i_use_blk ? i_blk_word : (s1 + i_win[9] + s0 + i_win[0]);
        a  = i_vars[0];
        e  = i_vars[4];
        t1 = i_vars[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
             + ((e & i_vars[5]) ^ (~e & i_vars[6])) + sha_pkg::round_const(i_rnd) + w;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
             + ((a & i_vars[1]) ^ (a & i_vars[2]) ^ (i_vars[1] & i_vars[2]));
        o_vars[7] = i_vars[6];
        o_vars[6] = i_vars[5];
        o_vars[5] = e;
        o_vars[4] = i_vars[3] + t1;
        o_vars[3] = i_vars[2];
        o_vars[2] = i_vars[1];
        o_vars[1] = a;
        o_vars[0] = t1 + t2;
        o_w = w;
    end

endmodule

@@ rtl/sha256_byte_stream_hasher.sv @@
// Top level of the SHA-256 byte stream hasher.
//
//  channel | dir | payload                              | beat
//  i_in    | in  | command, message_byte                | one byte or one finish
//  o_out   | out | digest_word, word_index, last_word   | one digest word
//
// The 64th byte of a block starts the memory prefetch, the 64 rounds of the single round
// unit and the chain update.
// A finish takes one or two block compressions, then eight output beats.
// Reset is synchronous; the block buffer needs no clearing pass.
// The input is held off while compressing or emitting; a stalled output holds its word.
module sha256_byte_stream_hasher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha_in_if.sink        i_in,
    sha_out_if.source     o_out
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_PAD1   = 2'd1;
    localparam logic [1:0] PH_LAST   = 2'd2;

    logic [2:0]     r_state;
    logic [1:0]     r_phase;
    logic [5:0]     r_fill;
    logic [63:0]    r_bits, r_total;
    logic [5:0]     r_rnd;
    logic [6:0]     r_nvalid;
    logic           r_mark, r_len;
    logic [2:0]     r_eidx;
    sha_pkg::t_word r_chain [8];
    sha_pkg::t_word r_vars [8];
    sha_pkg::t_word r_win [16];
    sha_pkg::t_word r_blk [16];
    sha_pkg::t_word r_rd;
    logic           r_ov;
    sha_pkg::t_word r_odata;
    logic [2:0]     r_oidx;
    logic           r_olast;

    sha_pkg::t_word n_vars [8];
    sha_pkg::t_word n_w;
    sha_pkg::t_word blk_word;
    logic [3:0]     rd_addr;
    logic           in_acc;
    logic [5:0]     pos;
    logic [3:0]     next_rnd;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.digest_word = r_odata;
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = r_olast;

    // Padding is applied on the fly as the block words are read out.
    always_comb begin
        blk_word = '0;
        for (int k = 0; k < 4; k++) begin
            pos = {r_rnd[3:0], 2'(k)};
            if ({1'b0, pos} < r_nvalid) begin
                blk_word[8*(3-k) +: 8] = r_rd[8*(3-k) +: 8];
            end else if (r_mark && pos == r_nvalid[5:0]) begin
                blk_word[8*(3-k) +: 8] = sha_pkg::PAD_MARK;
            end else if (r_len && pos >= 6'(sha_pkg::LEN_POS)) begin
                blk_word[8*(3-k) +: 8] = r_total[{~pos[2:0], 3'b000} +: 8];
            end
        end
    end

    assign next_rnd = r_rnd[3:0] + 4'd1;
    assign rd_addr  = (r_state == ST_ROUND) ? next_rnd : 4'd0;

    sha_round u_round (
        .i_vars     (r_vars),
        .i_win      (r_win),
        .i_blk_word (blk_word),
        .i_use_blk  (r_rnd < 6'd16),
        .i_rnd      (r_rnd),
        .o_vars     (n_vars),
        .o_w        (n_w)
    );

    // Block buffer memory: byte-lane writes, registered word read.
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_in.command) begin
            r_blk[r_fill[5:2]][8*(3-r_fill[1:0]) +: 8] <= i_in.message_byte;
        end
        r_rd <= r_blk[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_NORMAL;
            r_fill  <= '0;
            r_bits  <= '0;
            r_rnd   <= '0;
            r_eidx  <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < 8; i++) r_chain[i] <= sha_pkg::init_hash(3'(i));
        end else begin
            // While emitting, the output register is reloaded in the state below.
            if (r_ov && o_out.ready && r_state != ST_EMIT) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (!i_in.command) begin
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == 6'd63) begin
                                r_nvalid <= 7'd64;
                                r_mark   <= 1'b0;
                                r_len    <= 1'b0;
                                r_phase  <= PH_NORMAL;
                                r_state  <= ST_LOAD;
                            end
                        end else begin
                            r_total  <= r_bits + {55'd0, r_fill, 3'd0};
                            r_nvalid <= {1'b0, r_fill};
                            r_mark   <= 1'b1;
                            r_len    <= (r_fill < 6'(sha_pkg::LEN_POS));
                            r_phase  <= (r_fill < 6'(sha_pkg::LEN_POS)) ? PH_LAST : PH_PAD1;
                            r_state  <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    r_vars  <= r_chain;
                    r_rnd   <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_vars <= n_vars;
                    for (int i = 0; i < 15; i++) r_win[i] <= r_win[i+1];
                    r_win[15] <= n_w;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= ST_FINAL;
                end
                ST_FINAL: begin
                    for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_vars[i];
                    unique case (r_phase)
                        PH_NORMAL: begin
                            r_bits  <= r_bits + sha_pkg::BLOCK_BITS;
                            r_fill  <= '0;
                            r_state <= ST_IDLE;
                        end
                        PH_PAD1: begin
                            r_nvalid <= '0;
                            r_mark   <= 1'b0;
                            r_len    <= 1'b1;
                            r_phase  <= PH_LAST;
                            r_state  <= ST_LOAD;
                        end
                        default: begin
                            r_eidx  <= '0;
                            r_state <= ST_EMIT;
                        end
                    endcase
                end
                ST_EMIT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_odata <= r_chain[r_eidx];
                        r_oidx  <= r_eidx;
                        r_olast <= (r_eidx == 3'd7);
                        r_eidx  <= r_eidx + 3'd1;
                        if (r_eidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_chain[i] <= sha_pkg::init_hash(3'(i));
                            r_fill  <= '0;
                            r_bits  <= '0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_final_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL) |-> ($past(r_state) == ST_ROUND && $past(r_rnd) == 6'd63))
        else $error("chain update without 64 rounds");
    a_emit_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_olast) |-> (r_oidx == 3'd7))
        else $error("last word flagged out of order");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND || r_state == ST_EMIT) |-> !i_in.ready)
        else $error("input accepted while busy");
`endif

endmodule

@@ sim/tb_top.sv @@
// Testbench for the SHA-256 byte stream hasher with a digest predictor.
module tb_top;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_beat;

    logic i_clk;
    logic i_rst_n;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_byte_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Predictor state.
    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    int unsigned  msg_fill;
    logic [63:0]  msg_bits;

    t_digest_beat expected_words [$];
    int unsigned  mismatch_count;
    int unsigned  idle_cycles;
    bit           sink_idle_en;
    bit           src_idle_en;
    bit           hold_off_req;
    int unsigned  hold_off_len;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] k_const(input int unsigned t);
        logic [31:0] k [64];
        k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
              32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
              32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
              32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
              32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
              32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
              32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
              32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
              32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
              32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
              32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
              32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
              32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction

    task automatic load_initial_hash();
        hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                       32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    endtask

    task automatic compress_msg_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        v = hash_state;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(t) + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic predict_digest(input logic cmd, input logic [7:0] data);
        logic [63:0] total;
        int unsigned i;
        t_digest_beat beat;
        if (cmd == CMD_APPEND) begin
            msg_block[msg_fill] = data;
            msg_fill++;
            if (msg_fill == 64) begin
                compress_msg_block();
                msg_bits = msg_bits + 64'd512;
                msg_fill = 0;
            end
        end else begin
            total = msg_bits + 64'(msg_fill * 8);
            i = msg_fill;
            msg_block[i] = 8'h80;
            i++;
            if (msg_fill >= 56) begin
                while (i < 64) begin msg_block[i] = 8'h00; i++; end
                compress_msg_block();
                i = 0;
            end
            while (i < 56) begin msg_block[i] = 8'h00; i++; end
            for (int b = 0; b < 8; b++)
                msg_block[63-b] = total[8*b +: 8];
            compress_msg_block();
            for (int b = 0; b < 8; b++) begin
                beat.digest_word = hash_state[b];
                beat.word_index  = 3'(b);
                beat.last_word   = (b == 7);
                expected_words.push_back(beat);
            end
            load_initial_hash();
            msg_fill = 0;
            msg_bits = '0;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sends one beat, with a random idle burst beforehand when enabled.
    // Valid stays high after the beat; the next beat or the drain wait replaces it.
    task automatic send_beat(input logic cmd, input logic [7:0] data);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.message_byte <= data;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_digest(cmd, data);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned n = 0; n < len; n++)
            send_beat(CMD_APPEND, 8'($urandom_range(0, 255)));
        send_beat(CMD_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_digests_drained();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
    endtask

    // Output sink: random ready bursts and an optional long hold-off.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (hold_off_len) @(negedge i_clk);
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Compares each accepted digest beat with the oldest expected one.
    initial begin
        t_digest_beat got, want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.digest_word = out_ch.digest_word;
                got.word_index  = out_ch.word_index;
                got.last_word   = out_ch.last_word;
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat: word %h index %0d last %b",
                                 got.digest_word, got.word_index, got.last_word);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     want.digest_word, want.word_index, want.last_word,
                                     got.digest_word, got.word_index, got.last_word);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_beat(CMD_FINISH, 8'hff);            // empty message
        send_beat(CMD_APPEND, 8'h61);            // "abc"
        send_beat(CMD_APPEND, 8'h62);
        send_beat(CMD_APPEND, 8'h63);
        send_beat(CMD_FINISH, 8'h00);
        send_beat(CMD_APPEND, 8'h00);
        send_beat(CMD_APPEND, 8'hff);
        send_beat(CMD_APPEND, 8'h55);
        send_beat(CMD_APPEND, 8'haa);
        send_beat(CMD_FINISH, 8'h00);
        send_beat(CMD_FINISH, 8'h00);
        wait_digests_drained();
    endtask

    // Lengths around the padding boundaries: one or two padding blocks, a full block.
    task automatic test_block_boundaries();
        int unsigned lens [4] = '{55, 56, 63, 64};
        foreach (lens[i]) send_message(lens[i]);
        wait_digests_drained();
    endtask

    task automatic test_backpressure();
        hold_off_len = 300;
        hold_off_req = 1'b1;
        send_message(3);
        send_message(70);
        // Pause until every digest has come out.
        wait_digests_drained();
    endtask

    task automatic test_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 7) == 0) len = $urandom_range(0, 200);
            else len = $urandom_range(0, 70);
            send_message(len);
            sent += len + 1;
        end
    endtask

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.command      = CMD_APPEND;
        in_ch.message_byte = 8'h00;
        i_rst_n        = 1'b0;
        mismatch_count = 0;
        sink_idle_en   = 1'b0;
        src_idle_en    = 1'b0;
        hold_off_req   = 1'b0;
        hold_off_len   = 0;
        load_initial_hash();
        msg_fill = 0;
        msg_bits = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        sink_idle_en = 1'b1;
        src_idle_en  = 1'b1;
        test_directed();
        test_block_boundaries();
        test_backpressure();
        test_random(100);
        // Final stretch at full rate on both sides.
        sink_idle_en = 1'b0;
        src_idle_en  = 1'b0;
        test_random(60);

        wait_digests_drained();
        repeat (200) @(negedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
